FILE: rtl/core/utf8_to_utf16_decoder_unit_macros.svh
// assertion macros for the utf-8 to utf-16 decoder checker
// used by utfdec_checker; no other dependencies
`ifndef UTF8_TO_UTF16_DECODER_UNIT_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_UNIT_MACROS_SVH

// check on every clock edge outside reset
`define UTFDEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define UTFDEC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/utfdec_pkg.sv
// shared types and constants for the utf-8 to utf-16 decoder
// no dependencies; imported by every module of the block
`default_nettype none

package utfdec_pkg;

  // byte class boundaries
  localparam logic [7:0] CONT_BASE  = 8'h80;
  localparam logic [7:0] LEAD2_BASE = 8'hC0;
  localparam logic [7:0] LEAD3_BASE = 8'hE0;
  localparam logic [7:0] LEAD4_BASE = 8'hF0;
  localparam logic [7:0] LEAD5_BASE = 8'hF8;
  localparam logic [7:0] LEAD6_BASE = 8'hFC;

  // supplementary plane handling
  localparam logic [31:0] SUPP_BASE  = 32'h0001_0000;
  localparam logic [31:0] SUPP_SPAN  = 32'h0010_0000;
  localparam logic [31:0] SUPP_LIMIT = SUPP_BASE + SUPP_SPAN;
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [15:0] LO_SURR    = 16'hDC00;

  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  // most results one source byte can cause
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        unit_valid;
    logic        finished;
    logic        success;
    logic [15:0] unit_count;
    logic        last_of_run;
  } res_t;

  // all results of one byte, oldest in entry 0
  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [1:0]         num;
  } bundle_t;

endpackage

`default_nettype wire

FILE: rtl/core/utf8_to_utf16_decoder_unit.sv
// an accepted byte waits in the input register until its results have room, then is
// decoded and its results loaded into the result register. throughput: one byte per
// cycle while each byte gives at most one result and out_stall is low; a byte with
// more results holds the input, as the single result register emits one per transaction.
// reset (synchronous, active low) clears the decode state and empties both registers.
`default_nettype none

module utf8_to_utf16_decoder_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire utfdec_pkg::in_t  in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output utfdec_pkg::res_t      out_data
);
  import utfdec_pkg::*;

  logic    in_vld_r, in_vld_nxt;
  in_t     in_data_r;
  logic    adv;
  logic    accept;
  logic    can_load;
  bundle_t bundle;

  // the held byte is decoded once its results have room
  assign adv      = in_vld_r && ((bundle.num == 2'd0) || can_load);
  assign in_stall = in_vld_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data_r <= in_data;
    end
  end

  utfdec_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .in_data (in_data_r),
    .bundle  (bundle)
  );

  utfdec_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && (bundle.num != 2'd0)),
    .bundle    (bundle),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/core/utfdec_core.sv
// decode state and single-pass byte decode into a bundle of results
// depends on utfdec_pkg
`default_nettype none

module utfdec_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire utfdec_pkg::in_t    in_data,
  output utfdec_pkg::bundle_t     bundle
);
  import utfdec_pkg::*;

  logic [2:0]  pend_r, pend_nxt, pend_a;
  logic [31:0] acc_r, acc_nxt, acc_a;
  logic        halt_r, halt_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  logic [7:0]  b;
  logic        eos;
  logic        is_cont;
  logic        pv_do;
  logic [31:0] pv_val;
  logic        ended_a;
  logic        ok_main;

  logic        pv_big;
  logic        pv_fail;
  logic [31:0] pv_off;
  logic [1:0]  units;
  logic [15:0] u0, u1;
  logic [15:0] c1, c2, cnt_after;
  logic        ended_all;
  logic        ok;
  res_t        res_u0, res_u1, res_end;

  assign b       = in_data.byte_in;
  assign eos     = in_data.end_of_source;
  assign is_cont = (b[7:6] == 2'b10);

  // byte decode: sequence tracking and the one value this byte may emit
  always_comb begin
    pend_a  = pend_r;
    acc_a   = acc_r;
    pv_do   = 1'b0;
    pv_val  = '0;
    ended_a = 1'b0;
    ok_main = 1'b1;
    if (!halt_r) begin
      if (pend_r == 3'd0) begin
        priority if (b == 8'h00) begin
          ended_a = 1'b1;
        end else if (b < CONT_BASE) begin
          pv_do  = 1'b1;
          pv_val = {24'b0, b};
        end else if (b < LEAD2_BASE) begin
          // stray continuation byte
          ended_a = 1'b1;
          ok_main = 1'b0;
        end else if (b < LEAD3_BASE) begin
          acc_a  = {24'b0, b - LEAD2_BASE};
          pend_a = 3'd1;
        end else if (b < LEAD4_BASE) begin
          acc_a  = {24'b0, b - LEAD3_BASE};
          pend_a = 3'd2;
        end else if (b < LEAD5_BASE) begin
          acc_a  = {24'b0, b - LEAD4_BASE};
          pend_a = 3'd3;
        end else if (b < LEAD6_BASE) begin
          acc_a  = {24'b0, b - LEAD5_BASE};
          pend_a = 3'd4;
        end else begin
          acc_a  = {24'b0, b - LEAD6_BASE};
          pend_a = 3'd5;
        end
      end else begin
        priority if (b == 8'h00) begin
          // nul inside a sequence flushes the partial value
          pend_a  = 3'd0;
          pv_do   = 1'b1;
          pv_val  = acc_r;
          ended_a = 1'b1;
        end else if (is_cont) begin
          acc_a  = {acc_r[25:0], b[5:0]};
          pend_a = pend_r - 3'd1;
          if (pend_a == 3'd0) begin
            pv_do  = 1'b1;
            pv_val = acc_a;
          end
        end else begin
          // interrupted sequence: byte dropped, partial value emitted
          pend_a = 3'd0;
          pv_do  = 1'b1;
          pv_val = acc_r;
        end
      end
      // end of source closes the string, flushing any partial value
      if (!ended_a && eos) begin
        if (pend_a != 3'd0) begin
          pend_a = 3'd0;
          pv_do  = 1'b1;
          pv_val = acc_a;
        end
        ended_a = 1'b1;
      end
    end
  end

  // value to code units, surrogate split above the basic plane
  assign pv_big  = (pv_val >= SUPP_BASE);
  assign pv_fail = pv_do && (pv_val >= SUPP_LIMIT);
  assign pv_off  = pv_val - SUPP_BASE;
  assign u0      = pv_big ? (HI_SURR + {6'b0, pv_off[19:10]}) : pv_val[15:0];
  assign u1      = LO_SURR + {6'b0, pv_off[9:0]};

  always_comb begin
    if (!pv_do || pv_fail) begin
      units = 2'd0;
    end else if (!pv_big) begin
      units = 2'd1;
    end else begin
      units = 2'd2;
    end
  end

  // saturating unit counts after each emitted unit
  assign c1 = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 16'd1;
  assign c2 = (c1 == COUNT_MAX) ? c1 : c1 + 16'd1;

  always_comb begin
    unique case (units)
      2'd1:    cnt_after = c1;
      2'd2:    cnt_after = c2;
      default: cnt_after = cnt_r;
    endcase
  end

  assign ended_all = ended_a | pv_fail;
  assign ok        = ok_main & ~pv_fail;

  // result bundle in emission order
  always_comb begin
    res_u0  = '{unit: u0, unit_valid: 1'b1, finished: 1'b0, success: 1'b0,
                unit_count: c1, last_of_run: 1'b0};
    res_u1  = '{unit: u1, unit_valid: 1'b1, finished: 1'b0, success: 1'b0,
                unit_count: c2, last_of_run: 1'b0};
    res_end = '{unit: 16'h0000, unit_valid: 1'b0, finished: 1'b1, success: ok,
                unit_count: cnt_after, last_of_run: 1'b0};
    bundle.ent[0] = (units != 2'd0) ? res_u0 : res_end;
    bundle.ent[1] = (units == 2'd2) ? res_u1 : res_end;
    bundle.ent[2] = res_end;
    bundle.num    = units + {1'b0, ended_all};
  end

  // next state
  always_comb begin
    pend_nxt = pend_a;
    acc_nxt  = acc_a;
    halt_nxt = halt_r;
    cnt_nxt  = cnt_after;
    if (ended_all) begin
      pend_nxt = 3'd0;
      acc_nxt  = '0;
      halt_nxt = 1'b1;
    end
    // a marked byte after or at the end starts a fresh string
    if ((halt_r || ended_all) && eos) begin
      pend_nxt = 3'd0;
      acc_nxt  = '0;
      halt_nxt = 1'b0;
      cnt_nxt  = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
      acc_r  <= '0;
      halt_r <= 1'b0;
      cnt_r  <= '0;
    end else if (step_en) begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
      halt_r <= halt_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/utfdec_outq.sv
// result register holding one byte's bundle, emitted one result per transaction
// depends on utfdec_pkg
`default_nettype none

module utfdec_outq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire utfdec_pkg::bundle_t bundle,
  output logic                     can_load,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output utfdec_pkg::res_t         out_data
);
  import utfdec_pkg::*;

  logic [1:0]           left_r, left_nxt;
  res_t [MAX_RES-1:0]   ent_r;
  logic                 take;

  assign out_valid = (left_r != 2'd0);
  assign take      = out_valid && !out_stall;
  // free now, or the last held result leaves this cycle
  assign can_load  = (left_r == 2'd0) || (take && (left_r == 2'd1));

  // head entry, last-of-run marked from the remaining count
  always_comb begin
    out_data             = ent_r[0];
    out_data.last_of_run = (left_r == 2'd1);
  end

  always_comb begin
    if (load) begin
      left_nxt = bundle.num;
    end else if (take) begin
      left_nxt = left_r - 2'd1;
    end else begin
      left_nxt = left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 2'd0;
    end else begin
      left_r <= left_nxt;
    end
  end

  // payload: load a new bundle or shift towards the head
  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= bundle.ent;
    end else if (take) begin
      ent_r <= {res_t'('0), ent_r[2], ent_r[1]};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/utfdec_checker.sv
// port-level checks on the decoder result channel, bound to the top level
// depends on utfdec_pkg and utf8_to_utf16_decoder_unit_macros.svh
`default_nettype none

`include "utf8_to_utf16_decoder_unit_macros.svh"

module utfdec_checker (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             out_valid,
  input  wire logic             out_stall,
  input  wire utfdec_pkg::res_t out_data
);
  import utfdec_pkg::*;

  // a stalled result transaction holds
  `UTFDEC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  // a code unit never doubles as an end result
  `UTFDEC_ASSERT(a_unit_not_end, out_valid && out_data.unit_valid |-> !out_data.finished, "unit result flagged finished")
  // the end result is always the last result of its byte
  `UTFDEC_ASSERT(a_end_last, out_valid && out_data.finished |-> out_data.last_of_run, "end result not last of run")
  // success is only reported on end results
  `UTFDEC_ASSERT(a_unit_no_success, out_valid && out_data.unit_valid |-> !out_data.success, "success set on unit result")
  // no result is offered straight after reset
  `UTFDEC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind utf8_to_utf16_decoder_unit utfdec_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
